// File: rtl/dtc_pkg.sv
// Shared type, command codes, counter limit and helper function of the divider/timer block.
`default_nettype none

package dtc_pkg;

    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_RD_DIV    = 3'd1;
    localparam logic [2:0] CMD_RD_CNT    = 3'd2;
    localparam logic [2:0] CMD_WR_DIV    = 3'd3;
    localparam logic [2:0] CMD_WR_CNT    = 3'd4;
    localparam logic [2:0] CMD_WR_RELOAD = 3'd5;
    localparam logic [2:0] CMD_WR_CTL    = 3'd6;

    localparam logic [7:0] CNT_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_data;
    } t_item;

    // Selected divider bit for control select codes 0..3: bits 9, 3, 5, 7.
    function automatic logic sel_high(input logic [15:0] div, input logic [2:0] ctl);
        logic bit_val;
        case (ctl[1:0])
            2'd0:    bit_val = div[9];
            2'd1:    bit_val = div[3];
            2'd2:    bit_val = div[5];
            default: bit_val = div[7];
        endcase
        return bit_val;
    endfunction

endpackage

`default_nettype wire

// File: rtl/divider_timer_counter_top.sv
// Top level of the divider/timer block with its result register.
`default_nettype none

// The block takes one command word per cycle while not stalled and returns one result
// word for each. An accepted word waits in the input register and moves into the result
// register when that is empty or its output is not stalled. The divider, counter, reload
// and control registers are all updated in the single cycle in which a word moves from the
// input register to the result register. The configuration port is always ready.

module divider_timer_counter_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_cmd,
    input  wire logic [7:0] i_write_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_read_data,
    output logic            o_timer_irq,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_data
);

    logic           item_valid;
    dtc_pkg::t_item item;
    logic           advance;
    logic [7:0]     core_read_data;
    logic           core_irq;
    logic           r_out_valid;
    logic [7:0]     r_read_data;
    logic           r_timer_irq;

    assign advance     = item_valid && (!r_out_valid || !i_out_stall);
    assign o_cfg_ready = 1'b1;

    dtc_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_cmd        (i_cmd),
        .i_write_data (i_write_data),
        .i_advance    (advance),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    dtc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (advance),
        .i_item      (item),
        .o_read_data (core_read_data),
        .o_timer_irq (core_irq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data <= core_read_data;
            r_timer_irq <= core_irq;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_timer_irq = r_timer_irq;

    a_irq_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_timer_irq |-> o_read_data == 8'd0)
        else $error("Interrupt raised on a word that carries read data.");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_valid && !r_out_valid |=> r_out_valid)
        else $error("Held input word did not move into an empty result register.");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> item_valid && r_out_valid && i_out_stall)
        else $error("Input stalled while the pipeline had room.");

endmodule

`default_nettype wire

// File: rtl/dtc_in_stage.sv
// Input register stage that holds one accepted command word.
`default_nettype none

module dtc_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [2:0]    i_cmd,
    input  wire logic [7:0]    i_write_data,
    input  wire logic          i_advance,
    output logic               o_item_valid,
    output dtc_pkg::t_item     o_item
);

    logic           r_valid;
    logic           n_valid;
    dtc_pkg::t_item r_item;
    logic           accept;

    assign o_stall      = r_valid && !i_advance;
    assign accept       = i_valid && !o_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.cmd        <= i_cmd;
            r_item.write_data <= i_write_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dtc_core.sv
// Divider, counter, reload and control registers with their per-command update logic.
`default_nettype none

module dtc_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_data,
    input  wire logic           i_fire,
    input  wire dtc_pkg::t_item i_item,
    output logic [7:0]          o_read_data,
    output logic                o_timer_irq
);

    logic [15:0] r_div;
    logic [15:0] n_div;
    logic [7:0]  r_cnt;
    logic [7:0]  n_cnt;
    logic [7:0]  r_reload;
    logic [7:0]  n_reload;
    logic [2:0]  r_ctl;
    logic [2:0]  n_ctl;
    logic        r_double_speed;
    logic [15:0] div_step;
    logic        do_bump;
    logic [2:0]  new_ctl;

    assign div_step = r_div + (r_double_speed ? 16'd2 : 16'd1);
    assign new_ctl  = i_item.write_data[2:0];

    always_comb begin
        n_div       = r_div;
        n_reload    = r_reload;
        n_ctl       = r_ctl;
        n_cnt       = r_cnt;
        do_bump     = 1'b0;
        o_read_data = 8'd0;
        case (i_item.cmd)
            dtc_pkg::CMD_TICK: begin
                n_div   = div_step;
                do_bump = r_ctl[2] && dtc_pkg::sel_high(r_div, r_ctl)
                          && !dtc_pkg::sel_high(div_step, r_ctl);
            end
            dtc_pkg::CMD_RD_DIV: begin
                o_read_data = r_div[15:8];
            end
            dtc_pkg::CMD_RD_CNT: begin
                o_read_data = r_cnt;
            end
            dtc_pkg::CMD_WR_DIV: begin
                do_bump = r_ctl[2] && dtc_pkg::sel_high(r_div, r_ctl);
                n_div   = 16'd0;
            end
            dtc_pkg::CMD_WR_CNT: begin
                n_cnt = i_item.write_data;
            end
            dtc_pkg::CMD_WR_RELOAD: begin
                n_reload = i_item.write_data;
                n_cnt    = i_item.write_data;
            end
            dtc_pkg::CMD_WR_CTL: begin
                do_bump = r_ctl[2] && dtc_pkg::sel_high(r_div, r_ctl)
                          && !(new_ctl[2] && dtc_pkg::sel_high(r_div, new_ctl));
                n_ctl   = new_ctl;
            end
            default: begin
            end
        endcase
        o_timer_irq = do_bump && (r_cnt == dtc_pkg::CNT_MAX);
        if (do_bump) begin
            n_cnt = o_timer_irq ? r_reload : r_cnt + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div          <= 16'd0;
            r_cnt          <= 8'd0;
            r_reload       <= 8'd0;
            r_ctl          <= 3'd0;
            r_double_speed <= 1'b0;
        end else begin
            if (i_fire) begin
                r_div    <= n_div;
                r_cnt    <= n_cnt;
                r_reload <= n_reload;
                r_ctl    <= n_ctl;
            end
            if (i_cfg_we) begin
                r_double_speed <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/divider_timer_counter_top_tb.sv
// Self-checking testbench of the divider/timer block with its own timer predictor.
`default_nettype none

module divider_timer_counter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int TAC_EN = 2;
    localparam int TAP_BIT [4] = '{9, 3, 5, 7};
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [7:0] NEAR_MAX = 8'hF8;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } t_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [2:0] i_cmd = '0;
    logic [7:0] i_write_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_read_data;
    logic       o_timer_irq;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data = 1'b0;

    logic [15:0] div_q = '0;
    logic [7:0]  cnt_q = '0;
    logic [7:0]  reload_q = '0;
    logic [2:0]  ctl_q = '0;
    logic        dbl_q = 1'b0;

    t_result awaited_results [$];
    int      fail_count = 0;
    int      idle_pct = 0;
    int      stall_left = 0;
    int      quiet_cycles = 0;

    divider_timer_counter_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .o_timer_irq  (o_timer_irq),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic tap_high(input logic [15:0] div, input logic [2:0] ctl);
        return div[TAP_BIT[ctl[1:0]]];
    endfunction

    function automatic logic advance_counter();
        if (cnt_q == dtc_pkg::CNT_MAX) begin
            cnt_q = reload_q;
            return 1'b1;
        end
        cnt_q = cnt_q + 8'd1;
        return 1'b0;
    endfunction

    function automatic t_result timer_step(input logic [2:0] cmd, input logic [7:0] data);
        t_result     res;
        logic [15:0] nxt;
        logic [2:0]  new_ctl;
        logic        was_high;
        logic        stays_high;
        res = '0;
        case (cmd)
            dtc_pkg::CMD_TICK: begin
                nxt = div_q + (dbl_q ? 16'd2 : 16'd1);
                if (ctl_q[TAC_EN] && tap_high(div_q, ctl_q) && !tap_high(nxt, ctl_q)) begin
                    res.timer_irq = advance_counter();
                end
                div_q = nxt;
            end
            dtc_pkg::CMD_RD_DIV: begin
                res.read_data = div_q[15:8];
            end
            dtc_pkg::CMD_RD_CNT: begin
                res.read_data = cnt_q;
            end
            dtc_pkg::CMD_WR_DIV: begin
                if (ctl_q[TAC_EN] && tap_high(div_q, ctl_q)) begin
                    res.timer_irq = advance_counter();
                end
                div_q = '0;
            end
            dtc_pkg::CMD_WR_CNT: begin
                cnt_q = data;
            end
            dtc_pkg::CMD_WR_RELOAD: begin
                reload_q = data;
                cnt_q = data;
            end
            dtc_pkg::CMD_WR_CTL: begin
                new_ctl = data[2:0];
                if (ctl_q[TAC_EN]) begin
                    was_high = tap_high(div_q, ctl_q);
                    stays_high = new_ctl[TAC_EN] && tap_high(div_q, new_ctl);
                    if (was_high && !stays_high) begin
                        res.timer_irq = advance_counter();
                    end
                end
                ctl_q = new_ctl;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic send_word(input logic [2:0] cmd, input logic [7:0] data);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_write_data <= data;
        do @(posedge i_clk); while (o_in_stall);
        awaited_results.push_back(timer_step(cmd, data));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_double_speed(input logic value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        dbl_q = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_word(output logic [2:0] cmd, output logic [7:0] data);
        int pick;
        pick = $urandom_range(0, 99);
        data = 8'($urandom_range(0, 255));
        if (pick < 50) begin
            cmd = dtc_pkg::CMD_TICK;
        end else if (pick < 58) begin
            cmd = dtc_pkg::CMD_RD_DIV;
        end else if (pick < 66) begin
            cmd = dtc_pkg::CMD_RD_CNT;
        end else if (pick < 71) begin
            cmd = dtc_pkg::CMD_WR_DIV;
        end else if (pick < 79) begin
            cmd = dtc_pkg::CMD_WR_CNT;
            if ($urandom_range(0, 1) == 1) begin
                data = NEAR_MAX | {5'd0, data[2:0]};
            end
        end else if (pick < 85) begin
            cmd = dtc_pkg::CMD_WR_RELOAD;
        end else if (pick < 96) begin
            cmd = dtc_pkg::CMD_WR_CTL;
            if ($urandom_range(0, 4) != 0) begin
                data[TAC_EN] = 1'b1;
            end
        end else begin
            cmd = CMD_UNUSED;
        end
    endtask

    task automatic test_after_reset();
        send_word(dtc_pkg::CMD_RD_DIV, 8'h00);
        send_word(dtc_pkg::CMD_RD_CNT, 8'hFF);
        send_word(CMD_UNUSED, 8'hFF);
        send_word(CMD_UNUSED, 8'h00);
    endtask

    task automatic test_directed_cases();
        send_word(dtc_pkg::CMD_WR_RELOAD, 8'hFF);
        send_word(dtc_pkg::CMD_WR_CNT, 8'h00);
        send_word(dtc_pkg::CMD_RD_CNT, 8'h00);
        send_word(dtc_pkg::CMD_WR_CTL, 8'hFD);
        repeat (8) send_word(dtc_pkg::CMD_TICK, 8'hFF);
        send_word(dtc_pkg::CMD_WR_CNT, 8'hFF);
        send_word(dtc_pkg::CMD_WR_DIV, 8'hA5);
        send_word(dtc_pkg::CMD_RD_CNT, 8'h00);
        send_word(dtc_pkg::CMD_RD_DIV, 8'h00);
        repeat (8) send_word(dtc_pkg::CMD_TICK, 8'h00);
        send_word(dtc_pkg::CMD_WR_CTL, 8'h06);
        send_word(dtc_pkg::CMD_WR_CTL, 8'h05);
        send_word(dtc_pkg::CMD_WR_CTL, 8'h00);
        send_word(dtc_pkg::CMD_RD_CNT, 8'h00);
        send_word(dtc_pkg::CMD_WR_RELOAD, 8'h00);
    endtask

    task automatic test_double_speed_ticks();
        set_double_speed(1'b1);
        send_word(dtc_pkg::CMD_WR_DIV, 8'h00);
        send_word(dtc_pkg::CMD_WR_RELOAD, 8'hFE);
        send_word(dtc_pkg::CMD_WR_CTL, 8'h07);
        repeat (300) send_word(dtc_pkg::CMD_TICK, 8'h00);
        send_word(dtc_pkg::CMD_RD_DIV, 8'h00);
        send_word(dtc_pkg::CMD_RD_CNT, 8'h00);
    endtask

    task automatic test_random_traffic(input int count, input logic speed, input bit quiet);
        logic [2:0] cmd;
        logic [7:0] data;
        set_double_speed(speed);
        for (int n = 0; n < count; n++) begin
            if (quiet) begin
                idle_pct = 0;
            end else if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            end
            random_word(cmd, data);
            send_word(cmd, data);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || idle_pct == 0) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 7) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result word: read_data %0h, timer_irq %0b",
                       o_read_data, o_timer_irq);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected %0h, actual %0h", want.read_data, o_read_data);
                    fail_count++;
                end
                if (o_timer_irq !== want.timer_irq) begin
                    $error("timer_irq: expected %0b, actual %0b", want.timer_irq, o_timer_irq);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[divider_timer_counter_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        idle_pct = 15;
        test_after_reset();
        test_directed_cases();
        test_double_speed_ticks();
        test_random_traffic(500, 1'b0, 1'b0);
        test_random_traffic(500, 1'b1, 1'b0);
        test_random_traffic(500, 1'b0, 1'b1);
        drain_results();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[divider_timer_counter_top] OK");
        end else begin
            $display("[divider_timer_counter_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
